/* rtl/dmpi_pkg.sv */
`default_nettype none
package dmpi_pkg;

	localparam int unsigned DATA_W = 16;

	// register reset values
	localparam logic [DATA_W-1:0] TARGET_RST   = 16'd0;
	localparam logic [DATA_W-1:0] KP_LEFT_RST  = 16'd2000;
	localparam logic [DATA_W-1:0] KI_LEFT_RST  = 16'd6000;
	localparam logic [DATA_W-1:0] KP_RIGHT_RST = 16'd0;
	localparam logic [DATA_W-1:0] KI_RIGHT_RST = 16'd3000;
	localparam logic [DATA_W-1:0] MIN_DUTY_RST = 16'd0;
	localparam logic [DATA_W-1:0] MAX_DUTY_RST = 16'd10000;

	// integral state before the first write of a motor
	localparam logic [DATA_W-1:0] INTEG_RST = 16'd5000;

	// x / 10000 for any 32-bit x: (x * DIV_MAGIC) >> DIV_SHIFT, exact
	localparam logic [31:0] DIV_MAGIC = 32'd3518437209;
	localparam int unsigned DIV_SHIFT = 45;
	localparam int unsigned QUOT_W    = 19;

	typedef enum logic [3:0] {
		REG_TARGET_LEFT  = 4'd0,
		REG_TARGET_RIGHT = 4'd1,
		REG_KP_LEFT      = 4'd2,
		REG_KI_LEFT      = 4'd3,
		REG_KP_RIGHT     = 4'd4,
		REG_KI_RIGHT     = 4'd5,
		REG_MIN_DUTY     = 4'd6,
		REG_MAX_DUTY     = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic [DATA_W-1:0] target_left;
		logic [DATA_W-1:0] target_right;
		logic [DATA_W-1:0] kp_left;
		logic [DATA_W-1:0] ki_left;
		logic [DATA_W-1:0] kp_right;
		logic [DATA_W-1:0] ki_right;
		logic [DATA_W-1:0] min_duty;
		logic [DATA_W-1:0] max_duty;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic sel;
	} integ_rd_t;

	typedef struct packed {
		logic              en;
		logic              sel;
		logic [DATA_W-1:0] data;
	} integ_wr_t;

endpackage
`default_nettype wire

/* rtl/dmpi_cfg_regs.sv */
`default_nettype none
module dmpi_cfg_regs
	import dmpi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [3:0]        cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// always take a write beat
	assign cfg_ready = 1'b1;
	assign cfg        = cfg_q;

	// store the addressed register, drop writes beyond the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_left  <= TARGET_RST;
			cfg_q.target_right <= TARGET_RST;
			cfg_q.kp_left      <= KP_LEFT_RST;
			cfg_q.ki_left      <= KI_LEFT_RST;
			cfg_q.kp_right     <= KP_RIGHT_RST;
			cfg_q.ki_right     <= KI_RIGHT_RST;
			cfg_q.min_duty     <= MIN_DUTY_RST;
			cfg_q.max_duty     <= MAX_DUTY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TARGET_LEFT:  cfg_q.target_left  <= cfg_data;
				REG_TARGET_RIGHT: cfg_q.target_right <= cfg_data;
				REG_KP_LEFT:      cfg_q.kp_left      <= cfg_data;
				REG_KI_LEFT:      cfg_q.ki_left      <= cfg_data;
				REG_KP_RIGHT:     cfg_q.kp_right     <= cfg_data;
				REG_KI_RIGHT:     cfg_q.ki_right     <= cfg_data;
				REG_MIN_DUTY:     cfg_q.min_duty     <= cfg_data;
				REG_MAX_DUTY:     cfg_q.max_duty     <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/dmpi_integ_mem.sv */
`default_nettype none
module dmpi_integ_mem
	import dmpi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire integ_rd_t         rd,
	input  wire integ_wr_t         wr,
	output logic [DATA_W-1:0]      rd_data
);

	logic [DATA_W-1:0] mem_q [2];
	logic [1:0]        vld_q;
	logic [DATA_W-1:0] rd_raw_q;
	logic              rd_vld_q;
	logic              fwd_hit_q;
	logic [DATA_W-1:0] fwd_data_q;

	// storage and registered read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.sel] <= wr.data;
		end
		if (rd.en) begin
			rd_raw_q   <= mem_q[rd.sel];
			fwd_data_q <= wr.data;
		end
	end

	// track written entries, flag a write that lands on the entry being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.sel] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_q  <= vld_q[rd.sel];
				fwd_hit_q <= wr.en && (wr.sel == rd.sel);
			end
		end
	end

	// bypass the same-edge write, unwritten entries read as the reset value
	assign rd_data = fwd_hit_q ? fwd_data_q : (rd_vld_q ? rd_raw_q : INTEG_RST);

endmodule
`default_nettype wire

/* rtl/dual_motor_pi_duty_controller.sv */
// Dual-motor PI duty controller.
// Input channel (in_valid/in_ready): one tachometer sample per beat, motor_sel
// picks the motor, measured_speed is the speed in 0.1 RPM.
// Output channel (out_valid/out_ready): one result beat per sample, in order:
// motor_out, drive_level, backward and the PWM compare_value.
// Config channel (cfg_valid/cfg_ready): cfg_index selects one of the eight
// registers, cfg_data is written; indexes beyond the map are ignored. Write
// only while no sample is in flight.
// Throughput: one sample per cycle unless a held result stalls the stages. The
// per-motor integral lives in a small memory read as the item enters the update
// stage; the update written back at the same edge is bypassed into the next read,
// so samples of the same motor may follow each other back to back.
// Reset: registers take their defaults, both integrals read as 5000 until
// their first update. No clearing pass is needed.
// Stall: stages fill up behind a held result; in_ready drops once all four
// stages (three pipeline stages plus the output register) are occupied.
`default_nettype none
module dual_motor_pi_duty_controller
	import dmpi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [3:0]        cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              motor_sel,
	input  wire logic [DATA_W-1:0] measured_speed,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   motor_out,
	output logic [DATA_W-1:0]      drive_level,
	output logic                   backward,
	output logic [DATA_W-1:0]      compare_value
);

	localparam int unsigned SUM_W = 21;

	function automatic logic [QUOT_W-1:0] div_gain(input logic [31:0] x);
		logic [63:0] prod;
		prod = {32'd0, x} * {32'd0, DIV_MAGIC};
		return prod[63:DIV_SHIFT];
	endfunction

	function automatic logic [DATA_W-1:0] clamp_window(input logic signed [SUM_W-1:0] v,
		input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
		logic signed [SUM_W-1:0] r;
		logic signed [SUM_W-1:0] lo_s;
		logic signed [SUM_W-1:0] hi_s;
		lo_s = $signed({{(SUM_W-DATA_W){1'b0}}, lo});
		hi_s = $signed({{(SUM_W-DATA_W){1'b0}}, hi});
		r = v;
		if (r < lo_s) r = lo_s;
		if (r > hi_s) r = hi_s;
		return r[DATA_W-1:0];
	endfunction

	cfg_t      cfg;
	integ_rd_t mem_rd;
	integ_wr_t mem_wr;
	logic [DATA_W-1:0] integ_cur;

	dmpi_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dmpi_integ_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (mem_rd),
		.wr      (mem_wr),
		.rd_data (integ_cur)
	);

	// stage control
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic adv_out, en3, en2, en1;

	assign adv_out  = !out_valid_q || out_ready;
	assign en3      = !v_s3 || adv_out;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)     v_s1        <= in_valid;
			if (en2)     v_s2        <= v_s1;
			if (en3)     v_s3        <= v_s2;
			if (adv_out) out_valid_q <= v_s3;
		end
	end

	// stage 1: error magnitude and gain products
	logic              sel_s1;
	logic [DATA_W-1:0] speed_s1;
	logic [DATA_W-1:0] tgt_raw;
	logic              back_c1;
	logic              zero_c1;
	logic [16:0]       mag_c1;
	logic [17:0]       err_c1;
	logic [17:0]       err_neg_c1;
	logic [DATA_W-1:0] err_abs_c1;
	logic [DATA_W-1:0] kp_c1, ki_c1;
	logic [31:0]       pabs_c1, iabs_c1;

	assign tgt_raw    = sel_s1 ? cfg.target_right : cfg.target_left;
	assign back_c1    = tgt_raw[DATA_W-1];
	assign zero_c1    = (tgt_raw == '0);
	assign mag_c1     = back_c1 ? (17'd0 - {tgt_raw[DATA_W-1], tgt_raw}) : {1'b0, tgt_raw};
	assign err_c1     = {1'b0, mag_c1} - {2'b00, speed_s1};
	assign err_neg_c1 = 18'd0 - err_c1;
	assign err_abs_c1 = err_c1[17] ? err_neg_c1[DATA_W-1:0] : err_c1[DATA_W-1:0];
	assign kp_c1      = sel_s1 ? cfg.kp_right : cfg.kp_left;
	assign ki_c1      = sel_s1 ? cfg.ki_right : cfg.ki_left;
	assign pabs_c1    = {16'd0, kp_c1} * {16'd0, err_abs_c1};
	assign iabs_c1    = {16'd0, ki_c1} * {16'd0, err_abs_c1};

	// stage 2: divide the products by the gain scale
	logic              sel_s2, back_s2, zero_s2, neg_s2;
	logic [31:0]       pabs_s2, iabs_s2;
	logic [QUOT_W-1:0] pq_c2, iq_c2;

	assign pq_c2 = div_gain(pabs_s2);
	assign iq_c2 = div_gain(iabs_s2);

	// read the motor's integral as the item moves into stage 3
	assign mem_rd.en  = en3;
	assign mem_rd.sel = sel_s2;

	// stage 3: integral update, clamps and compare value
	logic              sel_s3, back_s3, zero_s3, neg_s3;
	logic [QUOT_W-1:0] pq_s3, iq_s3;
	logic signed [SUM_W-1:0] pq_sx, iq_sx, isum_c3, dsum_c3;
	logic [DATA_W-1:0] iclamp_c3;
	logic [DATA_W-1:0] drive_c3;
	logic [DATA_W-1:0] duty_c3;

	assign pq_sx     = $signed({{(SUM_W-QUOT_W){1'b0}}, pq_s3});
	assign iq_sx     = $signed({{(SUM_W-QUOT_W){1'b0}}, iq_s3});
	assign isum_c3   = $signed({{(SUM_W-DATA_W){1'b0}}, integ_cur}) + (neg_s3 ? -iq_sx : iq_sx);
	assign iclamp_c3 = clamp_window(isum_c3, cfg.min_duty, cfg.max_duty);
	assign dsum_c3   = (neg_s3 ? -pq_sx : pq_sx)
	                 + $signed({{(SUM_W-DATA_W){1'b0}}, iclamp_c3});
	assign drive_c3  = zero_s3 ? '0 : clamp_window(dsum_c3, cfg.min_duty, cfg.max_duty);
	assign duty_c3   = back_s3 ? (cfg.max_duty - drive_c3) : drive_c3;

	// write back as the item leaves stage 3
	assign mem_wr.en   = v_s3 && adv_out;
	assign mem_wr.sel  = sel_s3;
	assign mem_wr.data = zero_s3 ? '0 : iclamp_c3;

	// payload registers
	always_ff @(posedge clk) begin
		if (en1) begin
			sel_s1   <= motor_sel;
			speed_s1 <= measured_speed;
		end
		if (en2) begin
			sel_s2  <= sel_s1;
			back_s2 <= back_c1;
			zero_s2 <= zero_c1;
			neg_s2  <= err_c1[17];
			pabs_s2 <= pabs_c1;
			iabs_s2 <= iabs_c1;
		end
		if (en3) begin
			sel_s3  <= sel_s2;
			back_s3 <= back_s2;
			zero_s3 <= zero_s2;
			neg_s3  <= neg_s2;
			pq_s3   <= pq_c2;
			iq_s3   <= iq_c2;
		end
		if (adv_out) begin
			motor_out     <= sel_s3;
			drive_level   <= drive_c3;
			backward      <= back_s3;
			compare_value <= duty_c3 - 16'd1;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_ready_when_s1_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

	a_forward_compare: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !backward |-> compare_value == drive_level - 16'd1)
		else $error("forward compare value does not follow the drive");

	a_drive_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cfg.min_duty <= cfg.max_duty) && (drive_level != '0)
		|-> (drive_level >= cfg.min_duty) && (drive_level <= cfg.max_duty))
		else $error("drive outside the duty window");

	a_write_leaves_s3: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> mem_rd.en)
		else $error("integral write without a matching read slot");
`endif

endmodule
`default_nettype wire
